// File: rtl/cau_pkg.sv
// shared types and codes for the complex arithmetic unit
package cau_pkg;

    // operation selector carried in tuser
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DZ   = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    // control flags that follow a request down the divider chain
    typedef struct packed {
        op_t  op;
        logic zero;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
        logic sat;
    } ctrl_t;

endpackage

// File: rtl/cau_div_cell.sv
// one restoring division cell: produces one quotient bit per lane
module cau_div_cell #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load_en,
    input  logic                      in_valid,
    input  cau_pkg::ctrl_t            in_ctrl,
    input  logic [2*DATA_WIDTH-1:0]   in_den,
    input  logic [2*DATA_WIDTH-1:0]   in_rem_re,
    input  logic [2*DATA_WIDTH-1:0]   in_rem_im,
    input  logic [DATA_WIDTH-1:0]     in_nb_re,
    input  logic [DATA_WIDTH-1:0]     in_nb_im,
    input  logic [DATA_WIDTH-1:0]     in_q_re,
    input  logic [DATA_WIDTH-1:0]     in_q_im,
    output logic                      out_valid,
    output cau_pkg::ctrl_t            out_ctrl,
    output logic [2*DATA_WIDTH-1:0]   out_den,
    output logic [2*DATA_WIDTH-1:0]   out_rem_re,
    output logic [2*DATA_WIDTH-1:0]   out_rem_im,
    output logic [DATA_WIDTH-1:0]     out_nb_re,
    output logic [DATA_WIDTH-1:0]     out_nb_im,
    output logic [DATA_WIDTH-1:0]     out_q_re,
    output logic [DATA_WIDTH-1:0]     out_q_im
);

    localparam int PW = 2 * DATA_WIDTH;

    logic                  valid_reg;
    cau_pkg::ctrl_t        ctrl_reg;
    logic [PW-1:0]         den_reg;
    logic [PW-1:0]         rem_re_reg, rem_re_next;
    logic [PW-1:0]         rem_im_reg, rem_im_next;
    logic [DATA_WIDTH-1:0] nb_re_reg, nb_im_reg;
    logic [DATA_WIDTH-1:0] q_re_reg, q_re_next;
    logic [DATA_WIDTH-1:0] q_im_reg, q_im_next;
    logic [PW:0]           sh_re, sh_im;
    logic                  ge_re, ge_im;
    logic                  is_div;

    // shift in the next dividend bit, compare and subtract
    always_comb begin
        is_div = (in_ctrl.op == cau_pkg::OP_DIV);
        sh_re  = {in_rem_re, in_nb_re[DATA_WIDTH-1]};
        sh_im  = {in_rem_im, in_nb_im[DATA_WIDTH-1]};
        ge_re  = (sh_re >= {1'b0, in_den});
        ge_im  = (sh_im >= {1'b0, in_den});
        rem_re_next = ge_re ? PW'(sh_re - {1'b0, in_den}) : sh_re[PW-1:0];
        rem_im_next = ge_im ? PW'(sh_im - {1'b0, in_den}) : sh_im[PW-1:0];
        q_re_next = is_div ? {in_q_re[DATA_WIDTH-2:0], ge_re} : in_q_re;
        q_im_next = is_div ? {in_q_im[DATA_WIDTH-2:0], ge_im} : in_q_im;
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_en) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (load_en) begin
            ctrl_reg   <= in_ctrl;
            den_reg    <= in_den;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            nb_re_reg  <= {in_nb_re[DATA_WIDTH-2:0], 1'b0};
            nb_im_reg  <= {in_nb_im[DATA_WIDTH-2:0], 1'b0};
            q_re_reg   <= q_re_next;
            q_im_reg   <= q_im_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_ctrl   = ctrl_reg;
    assign out_den    = den_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_nb_re  = nb_re_reg;
    assign out_nb_im  = nb_im_reg;
    assign out_q_re   = q_re_reg;
    assign out_q_im   = q_im_reg;

endmodule

// File: rtl/complex_arithmetic_unit.sv
// complex add, subtract, multiply and divide on signed fixed-point operands
//
// Input stream: s_tuser carries the operation (add, subtract, multiply,
// divide), s_tdata the two complex operands. Output stream: m_tdata carries
// the real and imaginary result and a status code (ok, saturated, divide by
// zero). Each request gives exactly one result, in request order.
// The request passes the input register, one multiplier stage, a sum
// stage, a sign/magnitude stage, a quotient range check, one divider cell
// per quotient bit and the output register. The divider cells form a
// pipelined chain, so one request is taken per clock while the receiver
// does not stall. Each stage loads whenever it is empty or its successor
// loads, so when the receiver stalls, results pile up in the chain and
// s_tready drops only once every stage holds a request. Reset empties the
// pipeline; requests in flight are dropped and no results are created by
// it. There is no configuration and no stored state between requests.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // a_re, a_im, b_re, b_im from bit 0 up
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]           s_tdata,
    // req_type
    input  logic [1:0]                                  s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // res_re, res_im, status from bit 0 up
    output logic [((2*DATA_WIDTH+2+7)/8)*8-1:0]         m_tdata
);

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DW;
    localparam int SW  = 2 * DW + 1;
    localparam int NW  = PW + FRAC_BITS;
    localparam int MDW = ((2*DW+2+7)/8)*8;

    localparam logic signed [SW-1:0] SMAX = $signed({{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}});
    localparam logic signed [SW-1:0] SMIN = $signed({{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}});
    localparam logic [DW-1:0] DMAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DMIN  = {1'b1, {(DW-1){1'b0}}};

    // stage 0: input register
    logic                   v0_reg;
    cau_pkg::op_t           op0_reg;
    logic signed [DW-1:0]   ar0_reg, ai0_reg, br0_reg, bi0_reg;
    // stage 1: products and add/subtract results
    logic                   v1_reg;
    cau_pkg::op_t           op1_reg;
    logic signed [PW-1:0]   p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic [DW-1:0]          as_re_reg, as_im_reg;
    logic                   as_sat_reg;
    // stage 2: sums
    logic                   v2_reg;
    cau_pkg::op_t           op2_reg;
    logic signed [SW-1:0]   s_re_reg, s_im_reg;
    logic [PW-1:0]          den2_reg;
    logic [DW-1:0]          r2_re_reg, r2_im_reg;
    logic                   sat2_reg;
    // stage 3: sign and magnitude, multiply result
    logic                   v3_reg;
    cau_pkg::ctrl_t         ctrl3_reg, ctrl3_next;
    logic [PW-1:0]          den3_reg, mag_re_reg, mag_im_reg, mag_re_next, mag_im_next;
    logic [DW-1:0]          r3_re_reg, r3_im_reg, r3_re_next, r3_im_next;
    // stage 4: quotient range check and divider seed
    logic                   v4_reg;
    cau_pkg::ctrl_t         ctrl4_reg, ctrl4_next;
    logic [PW-1:0]          den4_reg, rem_re_reg, rem_im_reg;
    logic [DW-1:0]          nb_re_reg, nb_im_reg, q4_re_reg, q4_im_reg;
    logic [NW-1:0]          n_re, n_im, hi_re, hi_im;
    // output register
    logic                   out_valid_reg;
    logic [DW-1:0]          out_re_reg, out_re_next, out_im_reg, out_im_next;
    cau_pkg::status_t       out_st_reg, out_st_next;

    // divider chain, element 0 is the seed stage
    logic                   c_valid [0:DW];
    cau_pkg::ctrl_t         c_ctrl  [0:DW];
    logic [PW-1:0]          c_den   [0:DW];
    logic [PW-1:0]          c_rre   [0:DW];
    logic [PW-1:0]          c_rim   [0:DW];
    logic [DW-1:0]          c_nre   [0:DW];
    logic [DW-1:0]          c_nim   [0:DW];
    logic [DW-1:0]          c_qre   [0:DW];
    logic [DW-1:0]          c_qim   [0:DW];
    logic                   c_en    [1:DW+1];

    logic en0, en1, en2, en3, en4, en_out;
    logic signed [DW:0]     add_re, add_im;
    logic signed [SW-1:0]   sh_re, sh_im;
    logic                   sat_re, sat_im;

    // load enables: a stage loads when empty or when its successor loads
    assign en_out      = !out_valid_reg || m_tready;
    assign c_en[DW+1]  = en_out;
    for (genvar k = 1; k <= DW; k++) begin : g_en
        assign c_en[k] = !c_valid[k] || c_en[k+1];
    end
    assign en4 = !v4_reg || c_en[1];
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign s_tready = en0;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en0) v0_reg <= s_tvalid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en_out) out_valid_reg <= c_valid[DW];
        end
    end

    // stage 0 capture
    always_ff @(posedge aclk) begin
        if (en0) begin
            op0_reg <= cau_pkg::op_t'(s_tuser);
            ar0_reg <= $signed(s_tdata[DW-1:0]);
            ai0_reg <= $signed(s_tdata[2*DW-1:DW]);
            br0_reg <= $signed(s_tdata[3*DW-1:2*DW]);
            bi0_reg <= $signed(s_tdata[4*DW-1:3*DW]);
        end
    end

    // add or subtract with one guard bit
    always_comb begin
        if (op0_reg == cau_pkg::OP_SUB) begin
            add_re = (DW+1)'(ar0_reg) - (DW+1)'(br0_reg);
            add_im = (DW+1)'(ai0_reg) - (DW+1)'(bi0_reg);
        end else begin
            add_re = (DW+1)'(ar0_reg) + (DW+1)'(br0_reg);
            add_im = (DW+1)'(ai0_reg) + (DW+1)'(bi0_reg);
        end
    end

    // stage 1: products and clamped add/subtract
    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg   <= op0_reg;
            p_rr_reg  <= ar0_reg * br0_reg;
            p_ii_reg  <= ai0_reg * bi0_reg;
            p_ri_reg  <= ar0_reg * bi0_reg;
            p_ir_reg  <= ai0_reg * br0_reg;
            p_bb_reg  <= br0_reg * br0_reg;
            p_cc_reg  <= bi0_reg * bi0_reg;
            as_re_reg <= (add_re[DW] != add_re[DW-1]) ? (add_re[DW] ? DMIN : DMAX)
                                                      : add_re[DW-1:0];
            as_im_reg <= (add_im[DW] != add_im[DW-1]) ? (add_im[DW] ? DMIN : DMAX)
                                                      : add_im[DW-1:0];
            as_sat_reg <= (add_re[DW] != add_re[DW-1]) || (add_im[DW] != add_im[DW-1]);
        end
    end

    // stage 2: product sums and squared divisor magnitude
    always_ff @(posedge aclk) begin
        if (en2) begin
            op2_reg <= op1_reg;
            if (op1_reg == cau_pkg::OP_MUL) begin
                s_re_reg <= SW'(p_rr_reg) - SW'(p_ii_reg);
                s_im_reg <= SW'(p_ri_reg) + SW'(p_ir_reg);
            end else begin
                s_re_reg <= SW'(p_rr_reg) + SW'(p_ii_reg);
                s_im_reg <= SW'(p_ir_reg) - SW'(p_ri_reg);
            end
            den2_reg  <= $unsigned(p_bb_reg) + $unsigned(p_cc_reg);
            r2_re_reg <= as_re_reg;
            r2_im_reg <= as_im_reg;
            sat2_reg  <= as_sat_reg;
        end
    end

    // stage 3: multiply scaling, divide sign and magnitude
    always_comb begin
        sh_re  = s_re_reg >>> FRAC_BITS;
        sh_im  = s_im_reg >>> FRAC_BITS;
        sat_re = (sh_re > SMAX) || (sh_re < SMIN);
        sat_im = (sh_im > SMAX) || (sh_im < SMIN);
        ctrl3_next        = '0;
        ctrl3_next.op     = op2_reg;
        ctrl3_next.zero   = (den2_reg == '0);
        ctrl3_next.neg_re = s_re_reg[SW-1];
        ctrl3_next.neg_im = s_im_reg[SW-1];
        mag_re_next = s_re_reg[SW-1] ? PW'(-s_re_reg) : s_re_reg[PW-1:0];
        mag_im_next = s_im_reg[SW-1] ? PW'(-s_im_reg) : s_im_reg[PW-1:0];
        case (op2_reg)
            cau_pkg::OP_MUL: begin
                r3_re_next = sat_re ? (sh_re[SW-1] ? DMIN : DMAX) : sh_re[DW-1:0];
                r3_im_next = sat_im ? (sh_im[SW-1] ? DMIN : DMAX) : sh_im[DW-1:0];
                ctrl3_next.sat = sat_re || sat_im;
            end
            cau_pkg::OP_DIV: begin
                r3_re_next = '0;
                r3_im_next = '0;
            end
            default: begin
                r3_re_next = r2_re_reg;
                r3_im_next = r2_im_reg;
                ctrl3_next.sat = sat2_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            ctrl3_reg  <= ctrl3_next;
            den3_reg   <= den2_reg;
            mag_re_reg <= mag_re_next;
            mag_im_reg <= mag_im_next;
            r3_re_reg  <= r3_re_next;
            r3_im_reg  <= r3_im_next;
        end
    end

    // stage 4: quotient above the field range, and divider seed
    always_comb begin
        n_re  = NW'(mag_re_reg) << FRAC_BITS;
        n_im  = NW'(mag_im_reg) << FRAC_BITS;
        hi_re = n_re >> DW;
        hi_im = n_im >> DW;
        ctrl4_next        = ctrl3_reg;
        ctrl4_next.ovf_re = (hi_re >= NW'(den3_reg));
        ctrl4_next.ovf_im = (hi_im >= NW'(den3_reg));
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            ctrl4_reg  <= ctrl4_next;
            den4_reg   <= den3_reg;
            rem_re_reg <= hi_re[PW-1:0];
            rem_im_reg <= hi_im[PW-1:0];
            nb_re_reg  <= n_re[DW-1:0];
            nb_im_reg  <= n_im[DW-1:0];
            q4_re_reg  <= r3_re_reg;
            q4_im_reg  <= r3_im_reg;
        end
    end

    assign c_valid[0] = v4_reg;
    assign c_ctrl[0]  = ctrl4_reg;
    assign c_den[0]   = den4_reg;
    assign c_rre[0]   = rem_re_reg;
    assign c_rim[0]   = rem_im_reg;
    assign c_nre[0]   = nb_re_reg;
    assign c_nim[0]   = nb_im_reg;
    assign c_qre[0]   = q4_re_reg;
    assign c_qim[0]   = q4_im_reg;

    // one divider cell per quotient bit
    for (genvar k = 1; k <= DW; k++) begin : g_cell
        cau_div_cell #(
            .DATA_WIDTH(DW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load_en    (c_en[k]),
            .in_valid   (c_valid[k-1]),
            .in_ctrl    (c_ctrl[k-1]),
            .in_den     (c_den[k-1]),
            .in_rem_re  (c_rre[k-1]),
            .in_rem_im  (c_rim[k-1]),
            .in_nb_re   (c_nre[k-1]),
            .in_nb_im   (c_nim[k-1]),
            .in_q_re    (c_qre[k-1]),
            .in_q_im    (c_qim[k-1]),
            .out_valid  (c_valid[k]),
            .out_ctrl   (c_ctrl[k]),
            .out_den    (c_den[k]),
            .out_rem_re (c_rre[k]),
            .out_rem_im (c_rim[k]),
            .out_nb_re  (c_nre[k]),
            .out_nb_im  (c_nim[k]),
            .out_q_re   (c_qre[k]),
            .out_q_im   (c_qim[k])
        );
    end

    // final clamp of quotients and status
    always_comb begin
        logic s_re, s_im;
        s_re = 1'b0;
        s_im = 1'b0;
        out_re_next = c_qre[DW];
        out_im_next = c_qim[DW];
        out_st_next = c_ctrl[DW].sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        if (c_ctrl[DW].op == cau_pkg::OP_DIV) begin
            if (c_ctrl[DW].zero) begin
                out_re_next = '0;
                out_im_next = '0;
                out_st_next = cau_pkg::ST_DZ;
            end else begin
                if (c_ctrl[DW].neg_re) begin
                    s_re = c_ctrl[DW].ovf_re || (c_qre[DW] > DMIN);
                    out_re_next = s_re ? DMIN : DW'(-c_qre[DW]);
                end else begin
                    s_re = c_ctrl[DW].ovf_re || (c_qre[DW] > DMAX);
                    out_re_next = s_re ? DMAX : c_qre[DW];
                end
                if (c_ctrl[DW].neg_im) begin
                    s_im = c_ctrl[DW].ovf_im || (c_qim[DW] > DMIN);
                    out_im_next = s_im ? DMIN : DW'(-c_qim[DW]);
                end else begin
                    s_im = c_ctrl[DW].ovf_im || (c_qim[DW] > DMAX);
                    out_im_next = s_im ? DMAX : c_qim[DW];
                end
                out_st_next = (s_re || s_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en_out) begin
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
            out_st_reg <= out_st_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = MDW'({out_st_reg, out_im_reg, out_re_reg});

`ifndef NO_ASSERTIONS
    // divide by zero always gives a zero result
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_st_reg == cau_pkg::ST_DZ) |->
        (out_re_reg == '0 && out_im_reg == '0))
        else $error("divide by zero result not zero");

    // a saturated result has a part at a limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_st_reg == cau_pkg::ST_SAT) |->
        (out_re_reg == DMAX || out_re_reg == DMIN ||
         out_im_reg == DMAX || out_im_reg == DMIN))
        else $error("saturated status without a clamped part");

    // an empty input stage always takes a request
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v0_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // the reserved status code never appears
    a_no_rsvd: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_st_reg != cau_pkg::ST_RSVD))
        else $error("reserved status code on output");
`endif

endmodule
